### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/msti_pkg.sv
// ---------------------------------------------------------------------------
// msti_pkg
// Types and constants of the multi-servo timed move interpolator.
// ---------------------------------------------------------------------------
package msti_pkg;

    // Field widths
    localparam int unsigned POS_W  = 16;
    localparam int unsigned TIME_W = 16;
    localparam int unsigned NUM_W  = 6;
    localparam int unsigned MODE_W = 2;

    // Parameter defaults
    localparam int unsigned     NUM_SERVOS_DEF = 22;
    localparam logic [POS_W-1:0] CENTER_POS_DEF = 16'd1500;

    // Configuration register resets
    localparam logic [POS_W-1:0] MIN_POS_RST = 16'd500;
    localparam logic [POS_W-1:0] MAX_POS_RST = 16'd2500;

    // APB port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index, taken from address bit 2
    localparam logic REG_MIN_POS = 1'b0;
    localparam logic REG_MAX_POS = 1'b1;

    // Divider iteration count minus one
    localparam logic [3:0] DIV_LAST_CNT = 4'd15;

    typedef enum logic [MODE_W-1:0] {
        MODE_MOVE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_SET_ONE = 2'd2,
        MODE_SET_ALL = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV_RD,
        S_MV_WR,
        S_TK_RD,
        S_TK_CHK,
        S_DIV1,
        S_DIV2,
        S_TK_WB,
        S_EMIT
    } t_state;

endpackage

### rtl/core/multi_servo_timed_move_interpolator_core.sv
// ---------------------------------------------------------------------------
// multi_servo_timed_move_interpolator_core
// Per-servo position, goal and remaining time kept in one state memory;
// ticks walk every servo and step it toward its goal by a timed fraction.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   mode, servo_number, position,
//                                                 move_time_ms, elapsed_ms
//  output    out        o_out_valid / i_out_stall servo_index, to_all,
//                                                 out_position, last
//  config    in         APB psel/penable/pwrite   min_position, max_position
//
//  Move: read the entry, then write it back. Raw set: emit step, then output
//  wait. Tick: per servo read and check, two 16-step shift-subtract divisions
//  in one shared divider only when it interpolates, not when it snaps or holds;
//  then write-back and emit; one state memory read and write per servo.
//  Reset is synchronous; it clears the entry valid bits, so no clearing pass.
//  A stalled output holds the sequencer in its emit step; one new request
//  is taken only when the sequencer is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_servo_timed_move_interpolator_core
    import msti_pkg::*;
#(
    parameter int unsigned      NUM_SERVOS      = NUM_SERVOS_DEF,
    parameter logic [POS_W-1:0] CENTER_POSITION = CENTER_POS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [NUM_W-1:0]      i_servo_number,
    input  logic [POS_W-1:0]      i_position,
    input  logic [TIME_W-1:0]     i_move_time_ms,
    input  logic [TIME_W-1:0]     i_elapsed_ms,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [NUM_W-1:0]      o_servo_index,
    output logic                  o_to_all,
    output logic [POS_W-1:0]      o_out_position,
    output logic                  o_last
);

    localparam int unsigned IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int unsigned ENT_W = 2 * POS_W + TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVOS - 1);
    localparam logic [NUM_W:0]   NUM_MAX  = (NUM_W + 1)'(NUM_SERVOS);

    // State memory: {current, goal, time left}
    logic [ENT_W-1:0]      mem [NUM_SERVOS];
    logic [NUM_SERVOS-1:0] r_vld;
    logic [ENT_W-1:0]      r_rdata;
    logic                  r_rvld;

    t_state r_state, n_state;

    // Latched request
    t_mode             r_mode, n_mode;
    logic [IDX_W-1:0]  r_num_idx, n_num_idx;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [TIME_W-1:0] r_mt, n_mt;
    logic [TIME_W-1:0] r_el, n_el;
    logic [IDX_W-1:0]  r_idx, n_idx;

    // Working entry and divider
    logic [POS_W-1:0]  r_cur, n_cur;
    logic [POS_W-1:0]  r_goal, n_goal;
    logic [TIME_W-1:0] r_tl, n_tl;
    logic [15:0]       r_rem, n_rem;
    logic [15:0]       r_quo, n_quo;
    logic [15:0]       r_q1, n_q1;
    logic [3:0]        r_cnt, n_cnt;
    logic              r_neg, n_neg;

    // Staged result
    logic [NUM_W-1:0]  r_res_idx, n_res_idx;
    logic              r_res_all, n_res_all;
    logic [POS_W-1:0]  r_res_pos, n_res_pos;
    logic              r_res_last, n_res_last;

    // Output register
    logic              r_ov;
    logic [NUM_W-1:0]  r_o_idx;
    logic              r_o_all;
    logic [POS_W-1:0]  r_o_pos;
    logic              r_o_last;

    // Configuration
    logic [POS_W-1:0]  r_min, r_max;

    logic              in_acc;
    logic              tgt_ok;
    logic [IDX_W-1:0]  in_idx;
    logic              slot_free;
    logic              out_load;
    logic [POS_W-1:0]  ent_cur, ent_goal;
    logic [TIME_W-1:0] ent_tl;
    logic [15:0]       div_d;
    logic [16:0]       trial;
    logic [16:0]       trial_sub;
    logic              trial_ge;
    logic [15:0]       step_rem, step_quo;
    logic [15:0]       abs_diff;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa, mem_ra;
    logic [ENT_W-1:0]  mem_wd;
    logic              cfg_wr;

    // Request decode
    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign tgt_ok    = (i_servo_number != '0) && ({1'b0, i_servo_number} <= NUM_MAX)
                       && (i_position >= r_min) && (i_position <= r_max);
    assign in_idx    = IDX_W'(i_servo_number - NUM_W'(1));
    assign slot_free = !r_ov || !i_out_stall;
    assign out_load  = (r_state == S_EMIT) && slot_free;

    // Entry as read, with never-written entries at their reset value
    assign ent_cur  = r_rvld ? r_rdata[ENT_W-1 -: POS_W]          : CENTER_POSITION;
    assign ent_goal = r_rvld ? r_rdata[TIME_W +: POS_W]           : CENTER_POSITION;
    assign ent_tl   = r_rvld ? r_rdata[TIME_W-1:0]                : '0;

    // One restoring divider step, shared by both divisions
    assign div_d     = (r_state == S_DIV1) ? r_el : r_q1;
    assign trial     = {r_rem, r_quo[15]};
    assign trial_sub = trial - {1'b0, div_d};
    assign trial_ge  = trial >= {1'b0, div_d};
    assign step_rem  = trial_ge ? trial_sub[15:0] : trial[15:0];
    assign step_quo  = {r_quo[14:0], trial_ge};
    assign abs_diff  = (r_goal < r_cur) ? (r_cur - r_goal) : (r_goal - r_cur);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_mode))
                        MODE_MOVE:    n_state = tgt_ok ? S_MV_RD : S_IDLE;
                        MODE_TICK:    n_state = S_TK_RD;
                        MODE_SET_ONE: n_state = tgt_ok ? S_EMIT : S_IDLE;
                        MODE_SET_ALL: n_state = S_EMIT;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_MV_RD:  n_state = S_MV_WR;
            S_MV_WR:  n_state = S_IDLE;
            S_TK_RD:  n_state = S_TK_CHK;
            S_TK_CHK: begin
                if ((ent_tl == '0) || (r_el == '0) || (ent_tl <= r_el)) begin
                    n_state = S_TK_WB;
                end else begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1:   n_state = (r_cnt == '0) ? S_DIV2 : S_DIV1;
            S_DIV2:   n_state = (r_cnt == '0) ? S_TK_WB : S_DIV2;
            S_TK_WB:  n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) begin
                    n_state = r_res_last ? S_IDLE : S_TK_RD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb begin
        n_mode     = r_mode;
        n_num_idx  = r_num_idx;
        n_pos      = r_pos;
        n_mt       = r_mt;
        n_el       = r_el;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_goal     = r_goal;
        n_tl       = r_tl;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_q1       = r_q1;
        n_cnt      = r_cnt;
        n_neg      = r_neg;
        n_res_idx  = r_res_idx;
        n_res_all  = r_res_all;
        n_res_pos  = r_res_pos;
        n_res_last = r_res_last;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode    = t_mode'(i_mode);
                    n_num_idx = in_idx;
                    n_pos     = i_position;
                    n_mt      = i_move_time_ms;
                    n_el      = i_elapsed_ms;
                    n_idx     = '0;
                    n_res_idx = (t_mode'(i_mode) == MODE_SET_ONE)
                              ? (i_servo_number - NUM_W'(1)) : '0;
                    n_res_all  = (t_mode'(i_mode) == MODE_SET_ALL);
                    n_res_pos  = i_position;
                    n_res_last = 1'b1;
                end
            end
            S_TK_CHK: begin
                n_cur  = ent_cur;
                n_goal = ent_goal;
                n_tl   = ent_tl;
                if (ent_tl == '0) begin
                    n_cur = ent_goal;
                end else if (r_el == '0) begin
                    n_cur = ent_cur;
                end else if (ent_tl <= r_el) begin
                    n_cur = ent_goal;
                    n_tl  = '0;
                end else begin
                    n_rem = '0;
                    n_quo = ent_tl;
                    n_cnt = DIV_LAST_CNT;
                end
            end
            S_DIV1: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    // time_left / elapsed done; set up |diff| / quotient
                    n_q1  = step_quo;
                    n_rem = '0;
                    n_quo = abs_diff;
                    n_neg = r_goal < r_cur;
                    n_cnt = DIV_LAST_CNT;
                end
            end
            S_DIV2: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    n_cur = r_neg ? (r_cur - step_quo) : (r_cur + step_quo);
                    n_tl  = r_tl - r_el;
                end
            end
            S_TK_WB: begin
                n_res_idx  = NUM_W'(r_idx);
                n_res_all  = 1'b0;
                n_res_pos  = r_cur;
                n_res_last = (r_idx == LAST_IDX);
            end
            S_EMIT: begin
                if (slot_free && !r_res_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // Memory port selection
    assign mem_ra = (r_state == S_MV_RD) ? r_num_idx : r_idx;
    assign mem_we = (r_state == S_MV_WR) || (r_state == S_TK_WB);
    assign mem_wa = (r_state == S_MV_WR) ? r_num_idx : r_idx;
    assign mem_wd = (r_state == S_MV_WR) ? {ent_cur, r_pos, r_mt} : {r_cur, r_goal, r_tl};

    // State memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // Entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            r_rvld <= r_vld[mem_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_num_idx  <= n_num_idx;
        r_pos      <= n_pos;
        r_mt       <= n_mt;
        r_el       <= n_el;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_goal     <= n_goal;
        r_tl       <= n_tl;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_q1       <= n_q1;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_res_idx  <= n_res_idx;
        r_res_all  <= n_res_all;
        r_res_pos  <= n_res_pos;
        r_res_last <= n_res_last;
        if (out_load) begin
            r_o_idx  <= r_res_idx;
            r_o_all  <= r_res_all;
            r_o_pos  <= r_res_pos;
            r_o_last <= r_res_last;
        end
    end

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_POS_RST;
            r_max <= MAX_POS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_POS) begin
                r_max <= pwdata[POS_W-1:0];
            end else begin
                r_min <= pwdata[POS_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MIN_POS) ? APB_DATA_W'(r_min) : APB_DATA_W'(r_max);
    assign pready = 1'b1;

    // Ports
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_servo_index  = r_o_idx;
    assign o_to_all       = r_o_all;
    assign o_out_position = r_o_pos;
    assign o_last         = r_o_last;

    // Checks
    `ASSERT_IMP(a_div2_nonzero, i_clk, i_rst_n, r_state == S_DIV2, r_q1 != '0, "zero divisor in step division")
    `ASSERT_IMP(a_div1_case, i_clk, i_rst_n, r_state == S_DIV1, (r_el != '0) && (r_tl > r_el), "division entered on a snap or hold case")
    `ASSERT_NXT(a_load_from_emit, i_clk, i_rst_n, !r_ov && (r_state != S_EMIT), !r_ov, "output loaded outside emit step")
    `ASSERT_IMP(a_tick_mode, i_clk, i_rst_n, r_state == S_TK_CHK, r_mode == MODE_TICK, "servo walk outside a tick request")

endmodule

### bench/msti_drive_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// msti_drive_checker
// Watches the APB port and both request channels of the servo interpolator,
// keeps its own copy of the per-servo position, goal and time state, works
// out every servo drive a request causes and compares the drives that come
// out, in order, field by field.
// ---------------------------------------------------------------------------
module msti_drive_checker
    import msti_pkg::*;
#(
    parameter int unsigned      NUM_SERVOS      = NUM_SERVOS_DEF,
    parameter logic [POS_W-1:0] CENTER_POSITION = CENTER_POS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    // Input channel
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [NUM_W-1:0]      i_servo_number,
    input  logic [POS_W-1:0]      i_position,
    input  logic [TIME_W-1:0]     i_move_time_ms,
    input  logic [TIME_W-1:0]     i_elapsed_ms,
    // Output channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [NUM_W-1:0]      i_servo_index,
    input  logic                  i_to_all,
    input  logic [POS_W-1:0]      i_out_position,
    input  logic                  i_last,
    // Status toward the testbench top
    output int unsigned           o_fail_count,
    output int unsigned           o_pending,
    output int unsigned           o_checked
);

    typedef struct packed {
        logic [NUM_W-1:0] idx;
        logic             all;
        logic [POS_W-1:0] pos;
        logic             fin;
    } t_servo_drive;

    logic [POS_W-1:0]  cur_pos   [NUM_SERVOS];
    logic [POS_W-1:0]  goal_pos  [NUM_SERVOS];
    logic [TIME_W-1:0] time_left [NUM_SERVOS];
    logic [POS_W-1:0]  lim_min;
    logic [POS_W-1:0]  lim_max;
    t_servo_drive      drive_q[$];

    // Accept a servo number and target only inside the bank and the limits
    function automatic bit target_ok(logic [NUM_W-1:0] num, logic [POS_W-1:0] pos);
        return num >= 1 && num <= NUM_SERVOS && pos >= lim_min && pos <= lim_max;
    endfunction

    // Walk one servo by the elapsed time of a tick
    function automatic void advance_servo(int s, logic [TIME_W-1:0] el);
        int diff;
        int ratio;
        int step;
        if (time_left[s] == 0) begin
            cur_pos[s] = goal_pos[s];
        end else if (el == 0) begin
            // hold position and time left
        end else if (time_left[s] <= el) begin
            cur_pos[s]   = goal_pos[s];
            time_left[s] = '0;
        end else begin
            diff         = int'(goal_pos[s]) - int'(cur_pos[s]);
            ratio        = int'(time_left[s]) / int'(el);
            step         = diff / ratio;
            cur_pos[s]   = POS_W'(int'(cur_pos[s]) + step);
            time_left[s] = time_left[s] - el;
        end
    endfunction

    // Update the servo state for one request and queue the drives it causes
    function automatic void take_request(t_mode m, logic [NUM_W-1:0] num,
                                         logic [POS_W-1:0] pos,
                                         logic [TIME_W-1:0] mt,
                                         logic [TIME_W-1:0] el);
        t_servo_drive d;
        int           s;
        case (m)
            MODE_MOVE: begin
                if (target_ok(num, pos)) begin
                    goal_pos[int'(num) - 1]  = pos;
                    time_left[int'(num) - 1] = mt;
                end
            end
            MODE_TICK: begin
                for (s = 0; s < NUM_SERVOS; s++) begin
                    advance_servo(s, el);
                    d.idx = NUM_W'(s);
                    d.all = 1'b0;
                    d.pos = cur_pos[s];
                    d.fin = (s == NUM_SERVOS - 1);
                    drive_q.push_back(d);
                end
            end
            MODE_SET_ONE: begin
                if (target_ok(num, pos)) begin
                    d.idx = num - 1'b1;
                    d.all = 1'b0;
                    d.pos = pos;
                    d.fin = 1'b1;
                    drive_q.push_back(d);
                end
            end
            default: begin
                d.idx = '0;
                d.all = 1'b1;
                d.pos = pos;
                d.fin = 1'b1;
                drive_q.push_back(d);
            end
        endcase
    endfunction

    // Report one field that differs from what was expected
    function automatic bit field_ok(string name, int unsigned want, int unsigned got);
        if (want != got)
            $display("%0t: drive field %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
        return want == got;
    endfunction

    always @(posedge i_clk) begin : watch
        t_servo_drive want;
        bit           ok;
        if (!i_rst_n) begin
            // Restore the reset state of every servo and both limits
            for (int s = 0; s < NUM_SERVOS; s++) begin
                cur_pos[s]   = CENTER_POSITION;
                goal_pos[s]  = CENTER_POSITION;
                time_left[s] = '0;
            end
            lim_min = MIN_POS_RST;
            lim_max = MAX_POS_RST;
            drive_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Track limit register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_MAX_POS)
                    lim_max = i_pwdata[POS_W-1:0];
                else
                    lim_min = i_pwdata[POS_W-1:0];
            end
            // Predict on every accepted request
            if (i_in_valid && !i_in_stall)
                take_request(t_mode'(i_mode), i_servo_number, i_position,
                             i_move_time_ms, i_elapsed_ms);
            // Compare every accepted drive with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected drive: expected none, actual idx %0d pos %0d",
                             $time, i_servo_index, i_out_position);
                end else begin
                    want = drive_q.pop_front();
                    o_checked++;
                    ok = field_ok("servo_index", want.idx, i_servo_index);
                    ok = field_ok("to_all", want.all, i_to_all) && ok;
                    ok = field_ok("out_position", want.pos, i_out_position) && ok;
                    ok = field_ok("last", want.fin, i_last) && ok;
                    if (!ok)
                        o_fail_count++;
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule

### bench/multi_servo_timed_move_interpolator_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multi_servo_timed_move_interpolator_core_test
// Drives moves, ticks and raw sets into the servo interpolator under several
// limit settings, with random idling on both channels, a stretch with no
// idling and a long output hold-off; a checker beside the block predicts and
// compares every servo drive.
// ---------------------------------------------------------------------------
module multi_servo_timed_move_interpolator_core_test;
    import msti_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam logic [APB_ADDR_W-1:0] ADDR_MIN_POS = {REG_MIN_POS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_POS = {REG_MAX_POS, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode;
    logic [NUM_W-1:0]      servo_number;
    logic [POS_W-1:0]      position;
    logic [TIME_W-1:0]     move_time_ms;
    logic [TIME_W-1:0]     elapsed_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [NUM_W-1:0]      servo_index;
    logic                  to_all;
    logic [POS_W-1:0]      out_position;
    logic                  out_last;

    int unsigned      fail_count;
    int unsigned      pending;
    int unsigned      checked;
    int unsigned      cycle_count;
    int unsigned      mode_count [4];
    int unsigned      settings_count;
    bit               calm;
    int unsigned      hold_off_reqs;
    logic [POS_W-1:0] cfg_min;
    logic [POS_W-1:0] cfg_max;

    multi_servo_timed_move_interpolator_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (mode),
        .i_servo_number (servo_number),
        .i_position     (position),
        .i_move_time_ms (move_time_ms),
        .i_elapsed_ms   (elapsed_ms),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_servo_index  (servo_index),
        .o_to_all       (to_all),
        .o_out_position (out_position),
        .o_last         (out_last)
    );

    msti_drive_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_mode         (mode),
        .i_servo_number (servo_number),
        .i_position     (position),
        .i_move_time_ms (move_time_ms),
        .i_elapsed_ms   (elapsed_ms),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_servo_index  (servo_index),
        .i_to_all       (to_all),
        .i_out_position (out_position),
        .i_last         (out_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d drives still awaited",
                 $time, cycle_count, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output stall: random, quiet in calm phases, held for a long stretch on request
    initial begin : drive_stall
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_reqs != hold_seen) begin
                hold_seen = hold_off_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (calm) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 33);
            end
        end
    end

    // Offer one request, with a random gap first, and hold it until taken
    task automatic send_request(t_mode m, logic [NUM_W-1:0] num,
                                logic [POS_W-1:0] pos, logic [TIME_W-1:0] mt,
                                logic [TIME_W-1:0] el);
        while (!calm && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        servo_number <= num;
        position     <= pos;
        move_time_ms <= mt;
        elapsed_ms   <= el;
        do @(posedge i_clk); while (in_stall);
        mode_count[m]++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every drive is in and the block has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Stay idle before the next transfer
        @(negedge i_clk);
    endtask

    task automatic set_limits(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        wait_drained();
        write_reg(ADDR_MIN_POS, APB_DATA_W'(lo));
        write_reg(ADDR_MAX_POS, APB_DATA_W'(hi));
        cfg_min = lo;
        cfg_max = hi;
        settings_count++;
    endtask

    // Position inside the current limits, edges included; any position when the limits are crossed
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned roll;
        roll = $urandom_range(9);
        if (cfg_min > cfg_max)
            return POS_W'($urandom);
        if (roll == 0)
            return cfg_min;
        if (roll == 1)
            return cfg_max;
        return POS_W'($urandom_range(cfg_min, cfg_max));
    endfunction

    // One random request; useful is low when the block will ignore it
    task automatic send_random_request(output bit useful);
        int unsigned      pick;
        t_mode            m;
        logic [NUM_W-1:0] num;
        logic [POS_W-1:0] pos;
        logic [TIME_W-1:0] mt;
        logic [TIME_W-1:0] el;
        pick = $urandom_range(99);
        num  = NUM_W'($urandom_range(1, NUM_SERVOS_DEF));
        pos  = pick_position();
        mt   = ($urandom_range(9) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(400));
        el   = ($urandom_range(9) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(120));
        useful = 1'b1;
        if (pick < 45) begin
            m = MODE_MOVE;
        end else if (pick < 72) begin
            m = MODE_TICK;
        end else if (pick < 86) begin
            m = MODE_SET_ONE;
        end else if (pick < 94) begin
            m   = MODE_SET_ALL;
            pos = POS_W'($urandom);
        end else begin
            // broken request: servo outside the bank, any position
            m   = $urandom_range(1) ? MODE_MOVE : MODE_SET_ONE;
            num = $urandom_range(1) ? '0 : NUM_W'($urandom_range(NUM_SERVOS_DEF + 1, 63));
            pos = POS_W'($urandom);
        end
        if ((m == MODE_MOVE || m == MODE_SET_ONE) &&
            (num == 0 || num > NUM_SERVOS_DEF || pos < cfg_min || pos > cfg_max))
            useful = 1'b0;
        send_request(m, num, pos, mt, el);
    endtask

    task automatic run_random(int unsigned n);
        int unsigned done;
        bit          useful;
        done = 0;
        while (done < n) begin
            send_random_request(useful);
            if (useful)
                done++;
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        mode           = MODE_MOVE;
        servo_number   = '0;
        position       = '0;
        move_time_ms   = '0;
        elapsed_ms     = '0;
        calm           = 1'b0;
        hold_off_reqs  = 0;
        settings_count = 1;
        cfg_min        = MIN_POS_RST;
        cfg_max        = MAX_POS_RST;
        mode_count     = '{default: 0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Moves at the limit edges, zero and full times, rejected targets
        send_request(MODE_MOVE, 6'd1, 16'd500, 16'd0, 16'd0);
        send_request(MODE_MOVE, 6'd22, 16'd2500, 16'd1000, 16'd0);
        send_request(MODE_MOVE, 6'd2, 16'd2000, 16'd100, 16'd0);
        send_request(MODE_MOVE, 6'd3, 16'd1000, 16'd50, 16'd0);
        send_request(MODE_MOVE, 6'd4, 16'd600, 16'hFFFF, 16'd0);
        send_request(MODE_MOVE, 6'd0, 16'd1000, 16'd10, 16'd0);
        send_request(MODE_MOVE, 6'd23, 16'd1000, 16'd10, 16'd0);
        send_request(MODE_MOVE, 6'd63, 16'hFFFF, 16'd10, 16'hFFFF);
        send_request(MODE_MOVE, 6'd5, 16'd499, 16'd10, 16'd0);
        send_request(MODE_MOVE, 6'd5, 16'd2501, 16'd10, 16'd0);
        // Ticks: zero elapsed holds, small steps, exact and overshooting snaps
        send_request(MODE_TICK, 6'd0, 16'd0, 16'd0, 16'd0);
        send_request(MODE_TICK, 6'd0, 16'd0, 16'd0, 16'd1);
        send_request(MODE_TICK, 6'd0, 16'd0, 16'd0, 16'd40);
        send_request(MODE_TICK, 6'd0, 16'd0, 16'd0, 16'd60);
        send_request(MODE_TICK, 6'd0, 16'd0, 16'd0, 16'hFFFF);
        // Raw sets: edges, rejected servo and target, broadcast extremes
        send_request(MODE_SET_ONE, 6'd1, 16'd500, 16'd0, 16'd0);
        send_request(MODE_SET_ONE, 6'd22, 16'd2500, 16'd0, 16'd0);
        send_request(MODE_SET_ONE, 6'd0, 16'd1000, 16'd0, 16'd0);
        send_request(MODE_SET_ONE, 6'd6, 16'd3000, 16'd0, 16'd0);
        send_request(MODE_SET_ALL, 6'd0, 16'd0, 16'd0, 16'd0);
        send_request(MODE_SET_ALL, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(MODE_SET_ALL, 6'd0, 16'hA5A5, 16'd0, 16'd0);

        run_random(15);

        // Widest limits, no idling on either side
        set_limits(16'd0, 16'hFFFF);
        calm = 1'b1;
        run_random(20);
        calm = 1'b0;

        // Single accepted position
        set_limits(16'd1000, 16'd1000);
        run_random(8);

        // Crossed limits: every move and single set is rejected
        set_limits(16'd3000, 16'd2000);
        run_random(5);

        // Random limits; hold the output off so the block backs up its input
        lo = POS_W'($urandom_range(0, 30000));
        hi = POS_W'($urandom_range(lo, 65535));
        set_limits(lo, hi);
        hold_off_reqs++;
        send_request(MODE_TICK, 6'd0, 16'd0, 16'd0, 16'd7);
        run_random(20);

        wait_drained();
        $display("Covered %0d moves, %0d ticks, %0d single and %0d broadcast sets",
                 mode_count[MODE_MOVE], mode_count[MODE_TICK],
                 mode_count[MODE_SET_ONE], mode_count[MODE_SET_ALL]);
        $display("under %0d limit settings; %0d servo drives compared",
                 settings_count, checked);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
